// ===== rtl/core/cobs_enc_pkg.sv =====
// Package for the COBS frame encoder core: sizes, constants, the output source
// code and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package cobs_enc_pkg;

  localparam int BYTE_W    = 8;
  localparam int BUF_DEPTH = 62;
  localparam int CNT_W     = 6;
  localparam int MAX_MSG   = 62;

  localparam logic [BYTE_W-1:0] DELIM_BYTE = 8'h00;

  typedef enum logic [1:0] {
    SRC_CODE,
    SRC_DATA,
    SRC_DELIM
  } src_t;

  typedef struct packed {
    logic take;
    logic emit;
    src_t src;
    logic run_last;
    logic rd_first;
    logic rd_next;
    logic clr_group;
    logic clr_msg;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic grp_empty;
    logic rd_at_end;
    logic zero_flush;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/cobs_enc_in_if.sv =====
// Input channel of the COBS frame encoder: valid, ready and one message byte with its is_final flag.
// Depends on cobs_enc_pkg for the byte width.
`default_nettype none

interface cobs_enc_in_if;
  logic                            valid;
  logic                            ready;
  logic [cobs_enc_pkg::BYTE_W-1:0] data_byte;
  logic                            is_final;

  modport source (output valid, output data_byte, output is_final, input ready);
  modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cobs_enc_out_if.sv =====
// Result channel of the COBS frame encoder: valid, ready and one encoded byte
// with its run_last and overflow flags. Depends on cobs_enc_pkg.
`default_nettype none

interface cobs_enc_out_if;
  logic                            valid;
  logic                            ready;
  logic [cobs_enc_pkg::BYTE_W-1:0] out_byte;
  logic                            run_last;
  logic                            overflow;

  modport source (output valid, output out_byte, output run_last, output overflow,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input overflow,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cobs_enc_dpath.sv =====
// Datapath of the COBS frame encoder: group buffer memory, group and message
// counters, overflow flag and output register. Driven by cobs_enc_ctrl.
// Depends on cobs_enc_pkg.
`default_nettype none

module cobs_enc_dpath #(
  parameter int MAX_MSG = cobs_enc_pkg::MAX_MSG
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire cobs_enc_pkg::cmd_t         cmd,
  output cobs_enc_pkg::sts_t              sts,
  input  wire [cobs_enc_pkg::BYTE_W-1:0]  in_data,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [cobs_enc_pkg::BYTE_W-1:0] out_byte,
  output logic                            out_run_last,
  output logic                            out_overflow
);

  localparam int IDX_W = $clog2(cobs_enc_pkg::BUF_DEPTH);

  logic [cobs_enc_pkg::BYTE_W-1:0] mem [cobs_enc_pkg::BUF_DEPTH];
  logic [cobs_enc_pkg::BYTE_W-1:0] rd_data_r;

  logic [cobs_enc_pkg::CNT_W-1:0] gc_r;
  logic [cobs_enc_pkg::CNT_W-1:0] mc_r;
  logic                           ovf_r;
  logic [IDX_W-1:0]               rd_idx_r;

  logic                           out_valid_r;
  logic [cobs_enc_pkg::BYTE_W-1:0] out_byte_r;
  logic                           out_last_r;
  logic                           out_ovf_r;

  logic                           drop;
  logic                           data_nz;
  logic                           wr_en;
  logic                           grp_full;
  logic                           rd_en;
  logic [IDX_W-1:0]               rd_addr;
  logic [cobs_enc_pkg::BYTE_W-1:0] emit_byte;

  assign drop     = mc_r >= cobs_enc_pkg::CNT_W'(MAX_MSG);
  assign data_nz  = in_data != '0;
  assign grp_full = gc_r >= cobs_enc_pkg::CNT_W'(cobs_enc_pkg::BUF_DEPTH);
  assign wr_en    = cmd.take && !drop && data_nz && !grp_full;
  assign rd_en    = cmd.rd_first || cmd.rd_next;
  assign rd_addr  = cmd.rd_first ? '0 : rd_idx_r + IDX_W'(1);

  assign sts.slot_free  = !out_valid_r || out_ready;
  assign sts.grp_empty  = gc_r == '0;
  assign sts.rd_at_end  = IDX_W'(gc_r) == rd_idx_r + IDX_W'(1);
  assign sts.zero_flush = !drop && !data_nz;

  always_comb begin
    unique case (cmd.src)
      cobs_enc_pkg::SRC_CODE:  emit_byte = {{(cobs_enc_pkg::BYTE_W-cobs_enc_pkg::CNT_W){1'b0}},
                                            gc_r} + cobs_enc_pkg::BYTE_W'(1);
      cobs_enc_pkg::SRC_DATA:  emit_byte = rd_data_r;
      cobs_enc_pkg::SRC_DELIM: emit_byte = cobs_enc_pkg::DELIM_BYTE;
      default:                 emit_byte = cobs_enc_pkg::DELIM_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IDX_W'(gc_r)] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gc_r     <= '0;
      mc_r     <= '0;
      ovf_r    <= 1'b0;
      rd_idx_r <= '0;
    end else begin
      if (cmd.take) begin
        if (drop) begin
          ovf_r <= 1'b1;
        end else begin
          mc_r <= mc_r + cobs_enc_pkg::CNT_W'(1);
          if (data_nz) begin
            if (grp_full) begin
              ovf_r <= 1'b1;
            end else begin
              gc_r <= gc_r + cobs_enc_pkg::CNT_W'(1);
            end
          end
        end
      end
      if (rd_en) begin
        rd_idx_r <= rd_addr;
      end
      if (cmd.clr_group) begin
        gc_r <= '0;
      end
      if (cmd.clr_msg) begin
        mc_r  <= '0;
        ovf_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= cmd.run_last;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_last_r;
  assign out_overflow = out_ovf_r;

endmodule

`default_nettype wire

// ===== rtl/core/cobs_enc_ctrl.sv =====
// Controller of the COBS frame encoder: sequences code, data and delimiter
// bytes for each item that closes a group. Commands cobs_enc_dpath. Depends on cobs_enc_pkg.
`default_nettype none

module cobs_enc_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire                     in_is_final,
  input  wire cobs_enc_pkg::sts_t sts,
  output cobs_enc_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CODE,
    ST_DATA,
    ST_DELIM
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   final_r;
  logic   two_r;
  logic   two_nxt;
  state_t after_grp;

  assign in_ready = state_r == ST_IDLE;

  always_comb begin
    if (final_r) begin
      after_grp = two_r ? ST_CODE : ST_DELIM;
    end else begin
      after_grp = ST_IDLE;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.src   = cobs_enc_pkg::SRC_CODE;
    state_nxt = state_r;
    two_nxt   = two_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && (in_is_final || sts.zero_flush)) begin
          state_nxt = ST_CODE;
        end
      end
      ST_CODE: begin
        if (sts.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.src      = cobs_enc_pkg::SRC_CODE;
          cmd.run_last = sts.grp_empty && !final_r;
          if (sts.grp_empty) begin
            cmd.clr_group = 1'b1;
            state_nxt     = after_grp;
            two_nxt       = 1'b0;
          end else begin
            cmd.rd_first = 1'b1;
            state_nxt    = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (sts.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.src      = cobs_enc_pkg::SRC_DATA;
          cmd.run_last = sts.rd_at_end && !final_r;
          if (sts.rd_at_end) begin
            cmd.clr_group = 1'b1;
            state_nxt     = after_grp;
            two_nxt       = 1'b0;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      ST_DELIM: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.src       = cobs_enc_pkg::SRC_DELIM;
          cmd.run_last  = 1'b1;
          cmd.clr_group = 1'b1;
          cmd.clr_msg   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      final_r <= 1'b0;
      two_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.take) begin
        final_r <= in_is_final;
        two_r   <= in_is_final && sts.zero_flush;
      end else begin
        two_r <= two_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cobs_frame_encoder_core.sv =====
// COBS frame encoder core. Takes message bytes on in_if, with is_final on the
// last byte, and gives the stuffed frame on out_if: a code byte of group length
// plus one before each group of non-zero bytes, then a 0x00 delimiter at the end
// of each message. Messages longer than MAX_MSG bytes (62 by default) lose the
// excess bytes and show overflow. An item is taken while the controller is
// idle; an item that closes a group then holds the input while the code byte
// and the group's bytes go out, then the delimiter at the end of a message,
// with the code byte of an empty group before it after a final zero byte.
// Results go out at one a cycle through the single read port of the group
// buffer and the output register, while out_if does not stall. Other items
// do not hold the input. Depends on cobs_enc_pkg, the two channel interfaces,
// cobs_enc_ctrl and cobs_enc_dpath.
`default_nettype none

module cobs_frame_encoder_core #(
  parameter int MAX_MSG = cobs_enc_pkg::MAX_MSG
) (
  input  wire            clk,
  input  wire            rst_n,
  cobs_enc_in_if.sink    in_if,
  cobs_enc_out_if.source out_if
);

  cobs_enc_pkg::cmd_t cmd;
  cobs_enc_pkg::sts_t sts;

  cobs_enc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_ready    (in_if.ready),
    .in_is_final (in_if.is_final),
    .sts         (sts),
    .cmd         (cmd)
  );

  cobs_enc_dpath #(
    .MAX_MSG (MAX_MSG)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_data      (in_if.data_byte),
    .out_valid    (out_if.valid),
    .out_ready    (out_if.ready),
    .out_byte     (out_if.out_byte),
    .out_run_last (out_if.run_last),
    .out_overflow (out_if.overflow)
  );

endmodule

`default_nettype wire

// ===== tb/sv/cobs_frame_encoder_chk.sv =====
// Checker for the COBS frame encoder core: watches both channels, predicts the
// stuffed frame byte by byte and compares every accepted result in order.
// Depends on cobs_enc_pkg and the two channel interfaces.
`timescale 1ns / 100ps

module cobs_frame_encoder_chk (
  input  wire     clk,
  input  wire     rst_n,
  cobs_enc_in_if  in_ch,
  cobs_enc_out_if out_ch,
  output int      fail_cnt,
  output int      pending,
  output int      result_cnt,
  output int      frame_cnt,
  output int      ovf_frames
);

  typedef struct packed {
    logic [cobs_enc_pkg::BYTE_W-1:0] val;
    logic                            last;
    logic                            ovf;
  } enc_byte_t;

  enc_byte_t                       frame_q[$];
  logic [cobs_enc_pkg::BYTE_W-1:0] grp_buf [cobs_enc_pkg::BUF_DEPTH];
  logic [cobs_enc_pkg::CNT_W-1:0]  grp_len;
  logic [cobs_enc_pkg::CNT_W-1:0]  msg_len;
  logic                            drop_seen;

  task automatic report(input string what, input logic [cobs_enc_pkg::BYTE_W-1:0] got,
                        input logic [cobs_enc_pkg::BYTE_W-1:0] want);
    $display("[%0t] mismatch on %s: got 0x%02h, want 0x%02h", $time, what, got, want);
    fail_cnt++;
  endtask

  task automatic put_byte(input logic [cobs_enc_pkg::BYTE_W-1:0] b);
    frame_q.push_back('{val: b, last: 1'b0, ovf: drop_seen});
  endtask

  task automatic close_group();
    int k;
    put_byte({2'b00, grp_len} + 8'd1);
    for (k = 0; k < int'(grp_len); k++) put_byte(grp_buf[k]);
    grp_len = '0;
  endtask

  task automatic stuff_byte(input logic [cobs_enc_pkg::BYTE_W-1:0] d, input logic fin);
    int n0;
    n0 = frame_q.size();
    if (msg_len < cobs_enc_pkg::MAX_MSG) begin
      msg_len = msg_len + 1'b1;
      if (d != 8'h00) begin
        if (grp_len < cobs_enc_pkg::BUF_DEPTH) begin
          grp_buf[grp_len] = d;
          grp_len = grp_len + 1'b1;
        end else begin
          drop_seen = 1'b1;
        end
      end else begin
        close_group();
      end
    end else begin
      drop_seen = 1'b1;
    end
    if (fin) begin
      close_group();
      put_byte(cobs_enc_pkg::DELIM_BYTE);
      if (drop_seen) ovf_frames++;
      frame_cnt++;
      grp_len   = '0;
      msg_len   = '0;
      drop_seen = 1'b0;
    end
    if (frame_q.size() > n0) frame_q[frame_q.size()-1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    enc_byte_t want;
    if (!rst_n) begin
      frame_q.delete();
      grp_len   = '0;
      msg_len   = '0;
      drop_seen = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) stuff_byte(in_ch.data_byte, in_ch.is_final);
      if (out_ch.valid && out_ch.ready) begin
        result_cnt++;
        if (frame_q.size() == 0) begin
          report("out_byte with nothing expected", out_ch.out_byte, 8'h00);
        end else begin
          want = frame_q.pop_front();
          if (out_ch.out_byte !== want.val) report("out_byte", out_ch.out_byte, want.val);
          if (out_ch.run_last !== want.last)
            report("run_last", {7'd0, out_ch.run_last}, {7'd0, want.last});
          if (out_ch.overflow !== want.ovf)
            report("overflow", {7'd0, out_ch.overflow}, {7'd0, want.ovf});
        end
      end
    end
    pending = frame_q.size();
  end

endmodule

// ===== tb/sv/cobs_frame_encoder_core_tb.sv =====
// Testbench top for the COBS frame encoder core: drives message bytes and the
// result ready with random gaps, and gives the verdict from the checker.
// Depends on cobs_enc_pkg, the channel interfaces and cobs_frame_encoder_chk.
`timescale 1ns / 100ps

module cobs_frame_encoder_core_tb;

  logic clk;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;
  bit   rx_hold;
  int   sent_cnt;
  int   fail_cnt;
  int   pending;
  int   result_cnt;
  int   frame_cnt;
  int   ovf_frames;

  // bit 8 flags the last byte of a message
  logic [8:0] dir_seq [22] = '{
    9'h100, 9'h1FF, 9'h101,
    9'h000, 9'h100,
    9'h080, 9'h000, 9'h17F,
    9'h055, 9'h0AA, 9'h100,
    9'h000, 9'h012, 9'h1FE,
    9'h001, 9'h002, 9'h004, 9'h008, 9'h010, 9'h020, 9'h040, 9'h180
  };

  cobs_enc_in_if  in_if ();
  cobs_enc_out_if out_if ();

  cobs_frame_encoder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  cobs_frame_encoder_chk chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .fail_cnt   (fail_cnt),
    .pending    (pending),
    .result_cnt (result_cnt),
    .frame_cnt  (frame_cnt),
    .ovf_frames (ovf_frames)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    out_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // hold the result side off for a long stretch mid-run
  initial begin
    rx_hold = 1'b0;
    wait (sent_cnt >= 140);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(input logic [cobs_enc_pkg::BYTE_W-1:0] d, input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= d;
    in_if.is_final  <= fin;
    do @(posedge clk); while (!in_if.ready);
    sent_cnt++;
  endtask

  task automatic send_msg(input int len, input bit no_zero);
    int i;
    logic [cobs_enc_pkg::BYTE_W-1:0] d;
    for (i = 0; i < len; i++) begin
      if (!no_zero && $urandom_range(3) == 0) d = 8'h00;
      else d = cobs_enc_pkg::BYTE_W'($urandom_range(1, 255));
      send_item(d, i == len - 1);
    end
  endtask

  task automatic run_phase(input int tx, input int rx, input int long_len,
                           input bit long_no_zero, input int budget);
    int n;
    int k;
    int len;
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    n = 0;
    k = 0;
    while (n < budget) begin
      len = (k == 2) ? long_len : $urandom_range(1, 12);
      send_msg(len, long_no_zero && k == 2);
      n += len;
      k++;
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.is_final  = 1'b0;
    sent_cnt        = 0;
    tx_idle_pct     = 7;
    rx_idle_pct     = 48;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_seq[i]) send_item(dir_seq[i][7:0], dir_seq[i][8]);

    run_phase(7, 48, $urandom_range(63, 67), 1'b0, 83);
    run_phase(48, 7, cobs_enc_pkg::MAX_MSG, 1'b1, 83);
    run_phase(0, 0, $urandom_range(63, 70), 1'b0, 83);

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(posedge clk);

    $display("Encoded %0d message bytes in %0d frames (%0d overflowed).",
             sent_cnt, frame_cnt, ovf_frames);
    $display("Checked %0d result bytes under gaps, back pressure and a long stall.",
             result_cnt);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
